// ===== rtl/mcfs_pkg.sv =====
// Package for the metric coupled field force stencil.
// Grid constants, micro-op encoding, program tables and shared helpers.
// No dependencies.
package mcfs_pkg;

    localparam int GRID_SIDE = 32;
    localparam int NN        = GRID_SIDE * GRID_SIDE;
    localparam int CELLS     = NN * GRID_SIDE;
    localparam int AW        = $clog2(CELLS);
    localparam int XW        = $clog2(GRID_SIDE);
    localparam int TW        = $clog2(NN);
    localparam int CIW       = 15;
    localparam int DW        = 32;
    localparam int WW        = 3 * DW;
    localparam int FRAC      = 20;
    localparam int Q_ONE     = 1 << FRAC;
    localparam int OPA_W     = 36;
    localparam int OPB_W     = 33;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int FULL_W    = PROD_W - FRAC;
    localparam int ACC_W     = 48;
    localparam int NB        = 19;
    localparam int KW        = $clog2(NB + 1);
    localparam int NBW       = $clog2(NB);
    localparam int DIVN_W    = DW + FRAC;
    localparam int DCW       = $clog2(DIVN_W + 1);
    localparam int DD_W      = DW - 1;
    localparam int RSH       = 30;
    localparam int RECIP_NN  = (1 << RSH) / NN + 1;
    localparam int RECIP_N   = (1 << RSH) / GRID_SIDE + 1;
    localparam int RMW       = CIW + 31;
    localparam int SW        = 5;
    localparam int PRE_N     = 16;
    localparam int FLD_N     = 18;
    localparam int CFGW      = 3;

    localparam logic [CFGW-1:0] CFG_MU    = 3'd0;
    localparam logic [CFGW-1:0] CFG_KAPPA = 3'd1;
    localparam logic [CFGW-1:0] CFG_MASS  = 3'd2;
    localparam logic [CFGW-1:0] CFG_PAIR  = 3'd3;
    localparam logic [CFGW-1:0] CFG_ALPHA = 3'd4;
    localparam logic [CFGW-1:0] CFG_INV   = 3'd5;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC1, S_DEC2, S_READ, S_PRE, S_DIVST, S_DIV, S_FLD, S_FIN, S_DONE
    } t_state;

    typedef enum logic [1:0] {OFF_Z, OFF_P, OFF_M} t_off;

    typedef enum logic [3:0] {
        A_INV, A_GRD, A_PO1, A_T1, A_PP, A_KAPPA, A_DEN, A_MU,
        A_STN, A_H, A_CON, A_QUO, A_POTH, A_CTR
    } t_asrc;

    typedef enum logic [3:0] {
        B_INV, B_IDX1, B_IDX2, B_IDX4, B_PO2, B_CTR, B_PP, B_PP2,
        B_DEN, B_DV, B_ALPHA, B_DP, B_PAIR, B_MASS
    } t_bsrc;

    typedef enum logic [4:0] {
        D_IDX2, D_G, D_T1, D_PP, D_PP2, D_KPP, D_DEN2, D_NUM, D_LAP, D_DV,
        D_ACC0, D_ACC, D_ACC2, D_CORR, D_DP, D_FTR, D_FPW, D_FM
    } t_dst;

    typedef struct packed {
        t_asrc      asrc;
        t_bsrc      bsrc;
        t_dst       dst;
        logic [1:0] fld;
        logic [2:0] idx;
    } t_uop;

    function automatic t_uop mk(input t_asrc a, input t_bsrc b, input t_dst d,
                                input logic [1:0] f, input logic [2:0] i);
        t_uop u;
        u.asrc = a;
        u.bsrc = b;
        u.dst  = d;
        u.fld  = f;
        u.idx  = i;
        return u;
    endfunction

    // setup program: scale factors, gradients, triple product, denominator, numerator
    function automatic t_uop pre_uop(input logic [SW-1:0] s);
        t_uop u;
        case (s)
            5'd0:    u = mk(A_INV,   B_INV,  D_IDX2, 2'd0, 3'd0);
            5'd1:    u = mk(A_GRD,   B_IDX1, D_G,    2'd0, 3'd0);
            5'd2:    u = mk(A_GRD,   B_IDX1, D_G,    2'd1, 3'd0);
            5'd3:    u = mk(A_GRD,   B_IDX1, D_G,    2'd2, 3'd0);
            5'd4:    u = mk(A_GRD,   B_IDX1, D_G,    2'd0, 3'd1);
            5'd5:    u = mk(A_GRD,   B_IDX1, D_G,    2'd1, 3'd1);
            5'd6:    u = mk(A_GRD,   B_IDX1, D_G,    2'd2, 3'd1);
            5'd7:    u = mk(A_GRD,   B_IDX1, D_G,    2'd0, 3'd2);
            5'd8:    u = mk(A_GRD,   B_IDX1, D_G,    2'd1, 3'd2);
            5'd9:    u = mk(A_GRD,   B_IDX1, D_G,    2'd2, 3'd2);
            5'd10:   u = mk(A_PO1,   B_PO2,  D_T1,   2'd2, 3'd0);
            5'd11:   u = mk(A_T1,    B_CTR,  D_PP,   2'd2, 3'd0);
            5'd12:   u = mk(A_PP,    B_PP,   D_PP2,  2'd0, 3'd0);
            5'd13:   u = mk(A_KAPPA, B_PP2,  D_KPP,  2'd0, 3'd0);
            5'd14:   u = mk(A_DEN,   B_DEN,  D_DEN2, 2'd0, 3'd0);
            default: u = mk(A_MU,    B_PP,   D_NUM,  2'd0, 3'd0);
        endcase
        return u;
    endfunction

    // per-field program; field comes from the sequencer
    function automatic t_uop fld_uop(input logic [SW-1:0] s);
        t_uop u;
        case (s)
            5'd0:    u = mk(A_STN,  B_IDX2,  D_LAP,  2'd0, 3'd0);
            5'd1:    u = mk(A_STN,  B_IDX2,  D_DV,   2'd0, 3'd1);
            5'd2:    u = mk(A_STN,  B_IDX2,  D_DV,   2'd0, 3'd2);
            5'd3:    u = mk(A_STN,  B_IDX2,  D_DV,   2'd0, 3'd3);
            5'd4:    u = mk(A_STN,  B_IDX4,  D_DV,   2'd0, 3'd4);
            5'd5:    u = mk(A_STN,  B_IDX4,  D_DV,   2'd0, 3'd5);
            5'd6:    u = mk(A_STN,  B_IDX4,  D_DV,   2'd0, 3'd6);
            5'd7:    u = mk(A_H,    B_DV,    D_ACC0, 2'd0, 3'd0);
            5'd8:    u = mk(A_H,    B_DV,    D_ACC,  2'd0, 3'd1);
            5'd9:    u = mk(A_H,    B_DV,    D_ACC,  2'd0, 3'd2);
            5'd10:   u = mk(A_H,    B_DV,    D_ACC2, 2'd0, 3'd3);
            5'd11:   u = mk(A_H,    B_DV,    D_ACC2, 2'd0, 3'd4);
            5'd12:   u = mk(A_H,    B_DV,    D_ACC2, 2'd0, 3'd5);
            5'd13:   u = mk(A_CON,  B_ALPHA, D_CORR, 2'd0, 3'd0);
            5'd14:   u = mk(A_PO1,  B_PO2,   D_DP,   2'd0, 3'd0);
            5'd15:   u = mk(A_QUO,  B_DP,    D_FTR,  2'd0, 3'd0);
            5'd16:   u = mk(A_POTH, B_PAIR,  D_FPW,  2'd0, 3'd0);
            default: u = mk(A_CTR,  B_MASS,  D_FM,   2'd0, 3'd0);
        endcase
        return u;
    endfunction

    // neighbor list: center, faces, then xy, xz, yz corners
    function automatic t_off nb_dx(input logic [NBW-1:0] k);
        t_off o;
        case (k)
            5'd1, 5'd7, 5'd8, 5'd11, 5'd12:  o = OFF_P;
            5'd2, 5'd9, 5'd10, 5'd13, 5'd14: o = OFF_M;
            default:                         o = OFF_Z;
        endcase
        return o;
    endfunction

    function automatic t_off nb_dy(input logic [NBW-1:0] k);
        t_off o;
        case (k)
            5'd3, 5'd7, 5'd9, 5'd15, 5'd16:  o = OFF_P;
            5'd4, 5'd8, 5'd10, 5'd17, 5'd18: o = OFF_M;
            default:                         o = OFF_Z;
        endcase
        return o;
    endfunction

    function automatic t_off nb_dz(input logic [NBW-1:0] k);
        t_off o;
        case (k)
            5'd5, 5'd11, 5'd13, 5'd15, 5'd17: o = OFF_P;
            5'd6, 5'd12, 5'd14, 5'd16, 5'd18: o = OFF_M;
            default:                          o = OFF_Z;
        endcase
        return o;
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] fv(input logic [WW-1:0] w,
                                                input logic [1:0] f);
        logic signed [DW-1:0] r;
        case (f)
            2'd0:    r = w[DW-1:0];
            2'd1:    r = w[2*DW-1:DW];
            default: r = w[WW-1:2*DW];
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nxt(input logic [1:0] f);
        logic [1:0] r;
        case (f)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mcfs_req_if.sv =====
// Request channel: write or compute beat with cell and field values.
// Depends on mcfs_pkg.
interface mcfs_req_if import mcfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [CIW-1:0]        cell_index;
    logic signed [DW-1:0]  value_a;
    logic signed [DW-1:0]  value_b;
    logic signed [DW-1:0]  value_c;

    modport source (output valid, req_type, cell_index, value_a, value_b, value_c,
                    input ready);
    modport sink   (input valid, req_type, cell_index, value_a, value_b, value_c,
                    output ready);
endinterface

// ===== rtl/mcfs_res_if.sv =====
// Result channel: three saturated accelerations per beat.
// Depends on mcfs_pkg.
interface mcfs_res_if import mcfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [DW-1:0]  accel_a;
    logic signed [DW-1:0]  accel_b;
    logic signed [DW-1:0]  accel_c;

    modport source (output valid, accel_a, accel_b, accel_c, input ready);
    modport sink   (input valid, accel_a, accel_b, accel_c, output ready);
endinterface

// ===== rtl/metric_coupled_field_force_stencil_top.sv =====
// Top level: request decode, neighbor fetch, sequencer around one shared multiplier.
// Throughput: one compute at a time, set by the single multiplier, the divider and one
// store read per cycle for the 19 neighbor cells; writes take one per cycle while idle.
// Edge or out-of-grid computes present zeros.
// Reset: synchronous active low; control registers zero, inverse_spacing 1.0; store undefined.
module metric_coupled_field_force_stencil_top import mcfs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcfs_req_if.sink        i_req,
    mcfs_res_if.source      o_res,
    input  logic            i_cfg_we,
    input  logic [CFGW-1:0] i_cfg_idx,
    input  logic [DW-1:0]   i_cfg_data
);
    t_state r_state, n_state;

    logic signed [DW-1:0] r_mu, r_pair, r_alpha;
    logic [DW-2:0]        r_kappa, r_mass, r_inv;

    logic [CIW-1:0] r_cell;
    logic [XW-1:0]  r_x, r_y, r_z;
    logic [TW-1:0]  r_t;
    logic [KW-1:0]  r_k;
    logic [WW-1:0]  r_nb [NB];
    logic [SW-1:0]  r_step;
    logic           r_wb;
    logic [1:0]     r_fld;

    logic signed [DW-1:0]    r_idx2, r_t1, r_pp, r_pp2, r_kpp, r_den2, r_num, r_quo;
    logic signed [DW-1:0]    r_lap, r_corr, r_dp, r_ftr, r_fpw, r_fm;
    logic signed [DW-1:0]    r_g [9];
    logic signed [DW-1:0]    r_dv [6];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [DW-1:0]    r_res [3];
    logic                    r_out_valid;
    logic signed [DW-1:0]    r_out [3];

    logic          w_acc_in, w_wr, w_inrange, w_edge_ok;
    logic          w_mem_re, w_mul_en, w_div_start, w_out_load;
    logic [AW-1:0] w_raddr;
    logic [WW-1:0] w_rdata;
    logic [RMW-1:0] w_xq, w_yq;
    logic [XW-1:0] w_ynext, w_znext;
    logic [XW-1:0] w_xs, w_ys, w_zs, w_kp, w_km;

    t_uop                    w_uop;
    logic [1:0]              w_fld;
    logic signed [OPA_W-1:0] w_a;
    logic signed [OPB_W-1:0] w_b;
    logic signed [FULL_W-1:0] w_full;
    logic signed [DW-1:0]    w_sat;
    logic                    w_div_done;
    logic signed [DW-1:0]    w_div_quo;

    logic signed [OPA_W-1:0] w_v [NB];
    logic signed [OPA_W-1:0] w_stn [7];
    logic signed [OPA_W-1:0] w_grd [3];
    logic signed [DW-1:0]    w_h [6];
    logic signed [DW-1:0]    w_p [3];
    logic signed [DW-1:0]    w_idx1, w_idx4, w_den, w_con, w_fin;
    logic [1:0]              w_o1, w_o2;

    // ---------------- handshake / decode ----------------
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc_in    = i_req.valid && i_req.ready;
    assign w_wr        = w_acc_in && (i_req.req_type == REQ_WRITE)
                         && (32'(i_req.cell_index) < 32'(CELLS));

    assign w_xq      = (RMW'(r_cell) * RMW'(RECIP_NN)) >> RSH;
    assign w_yq      = (RMW'(r_t) * RMW'(RECIP_N)) >> RSH;
    assign w_ynext   = w_yq[XW-1:0];
    assign w_znext   = XW'(r_t - TW'(w_ynext) * TW'(GRID_SIDE));
    assign w_inrange = 32'(r_cell) < 32'(CELLS);
    assign w_edge_ok = (r_x >= XW'(2)) && (r_x <= XW'(GRID_SIDE - 3))
                       && (w_ynext >= XW'(2)) && (w_ynext <= XW'(GRID_SIDE - 3));

    // ---------------- neighbor address ----------------
    assign w_kp = (r_z == XW'(GRID_SIDE - 1)) ? '0 : r_z + 1'b1;
    assign w_km = (r_z == '0) ? XW'(GRID_SIDE - 1) : r_z - 1'b1;

    always_comb begin
        case (nb_dx(r_k[NBW-1:0]))
            OFF_P:   w_xs = r_x + 1'b1;
            OFF_M:   w_xs = r_x - 1'b1;
            default: w_xs = r_x;
        endcase
        case (nb_dy(r_k[NBW-1:0]))
            OFF_P:   w_ys = r_y + 1'b1;
            OFF_M:   w_ys = r_y - 1'b1;
            default: w_ys = r_y;
        endcase
        case (nb_dz(r_k[NBW-1:0]))
            OFF_P:   w_zs = w_kp;
            OFF_M:   w_zs = w_km;
            default: w_zs = r_z;
        endcase
    end

    assign w_raddr = AW'(w_xs) * AW'(NN) + AW'(w_ys) * AW'(GRID_SIDE) + AW'(w_zs);

    mcfs_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (AW'(i_req.cell_index)),
        .i_wdata ({i_req.value_c, i_req.value_b, i_req.value_a}),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- operand formation ----------------
    assign w_uop = (r_state == S_PRE) ? pre_uop(r_step) : fld_uop(r_step);
    assign w_fld = (r_state == S_PRE) ? w_uop.fld : r_fld;
    assign w_o1  = nxt(w_fld);
    assign w_o2  = nxt(w_o1);

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            w_v[k] = OPA_W'(fv(r_nb[k], w_fld));
        end
        for (int f = 0; f < 3; f++) begin
            w_p[f] = fv(r_nb[0], 2'(f));
        end
        w_stn[0] = w_v[1] + w_v[2] + w_v[3] + w_v[4] + w_v[5] + w_v[6]
                   - 6 * w_v[0];
        w_stn[1] = w_v[1] - 2 * w_v[0] + w_v[2];
        w_stn[2] = w_v[3] - 2 * w_v[0] + w_v[4];
        w_stn[3] = w_v[5] - 2 * w_v[0] + w_v[6];
        w_stn[4] = w_v[7] - w_v[8] - w_v[9] + w_v[10];
        w_stn[5] = w_v[11] - w_v[12] - w_v[13] + w_v[14];
        w_stn[6] = w_v[15] - w_v[16] - w_v[17] + w_v[18];
        w_grd[0] = w_v[1] - w_v[2];
        w_grd[1] = w_v[3] - w_v[4];
        w_grd[2] = w_v[5] - w_v[6];
        w_h[0] = sat32(64'(r_g[0]) + 64'(r_g[0]));
        w_h[1] = sat32(64'(r_g[4]) + 64'(r_g[4]));
        w_h[2] = sat32(64'(r_g[8]) + 64'(r_g[8]));
        w_h[3] = sat32(64'(r_g[1]) + 64'(r_g[3]));
        w_h[4] = sat32(64'(r_g[2]) + 64'(r_g[6]));
        w_h[5] = sat32(64'(r_g[5]) + 64'(r_g[7]));
    end

    assign w_idx1 = DW'({1'b0, r_inv} >> 1);
    assign w_idx4 = r_idx2 >>> 2;
    assign w_den  = sat32(64'(Q_ONE) + 64'(r_kpp));
    assign w_con  = sat32(64'(r_acc));

    always_comb begin
        case (w_uop.asrc)
            A_INV:   w_a = OPA_W'({1'b0, r_inv});
            A_GRD:   w_a = w_grd[w_uop.idx[1:0]];
            A_PO1:   w_a = OPA_W'(w_p[w_o1]);
            A_T1:    w_a = OPA_W'(r_t1);
            A_PP:    w_a = OPA_W'(r_pp);
            A_KAPPA: w_a = OPA_W'({1'b0, r_kappa});
            A_DEN:   w_a = OPA_W'(w_den);
            A_MU:    w_a = OPA_W'(r_mu);
            A_STN:   w_a = w_stn[w_uop.idx];
            A_H:     w_a = OPA_W'(w_h[w_uop.idx]);
            A_CON:   w_a = OPA_W'(w_con);
            A_QUO:   w_a = OPA_W'(r_quo);
            A_POTH:  w_a = OPA_W'(w_p[w_o1]) + OPA_W'(w_p[w_o2]);
            A_CTR:   w_a = OPA_W'(w_p[w_fld]);
            default: w_a = '0;
        endcase
        case (w_uop.bsrc)
            B_INV:   w_b = OPB_W'({1'b0, r_inv});
            B_IDX1:  w_b = OPB_W'(w_idx1);
            B_IDX2:  w_b = OPB_W'(r_idx2);
            B_IDX4:  w_b = OPB_W'(w_idx4);
            B_PO2:   w_b = OPB_W'(w_p[w_o2]);
            B_CTR:   w_b = OPB_W'(w_p[w_fld]);
            B_PP:    w_b = OPB_W'(r_pp);
            B_PP2:   w_b = OPB_W'(r_pp2);
            B_DEN:   w_b = OPB_W'(w_den);
            B_DV:    w_b = OPB_W'(r_dv[w_uop.idx]);
            B_ALPHA: w_b = OPB_W'(r_alpha);
            B_DP:    w_b = OPB_W'(r_dp);
            B_PAIR:  w_b = OPB_W'(r_pair);
            B_MASS:  w_b = OPB_W'({1'b0, r_mass});
            default: w_b = '0;
        endcase
    end

    mcfs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_full (w_full),
        .o_sat  (w_sat)
    );

    mcfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den2[DD_W-1:0]),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_fin = sat32(64'(r_lap) + 64'(r_corr) - 64'(r_fm) - 64'(r_ftr) - 64'(r_fpw));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_acc_in && i_req.req_type == REQ_COMPUTE) n_state = S_DEC1;
            S_DEC1:  n_state = S_DEC2;
            S_DEC2:  n_state = (w_inrange && w_edge_ok) ? S_READ : S_DONE;
            S_READ:  if (r_k == KW'(NB)) n_state = S_PRE;
            S_PRE:   if (r_wb && r_step == SW'(PRE_N - 1)) n_state = S_DIVST;
            S_DIVST: n_state = (r_den2 > 0) ? S_DIV : S_FLD;
            S_DIV:   if (w_div_done) n_state = S_FLD;
            S_FLD:   if (r_wb && r_step == SW'(FLD_N - 1)) n_state = S_FIN;
            S_FIN:   n_state = (r_fld == 2'd2) ? S_DONE : S_FLD;
            S_DONE:  if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        w_mem_re    = (r_state == S_READ) && (r_k < KW'(NB));
        w_mul_en    = ((r_state == S_PRE) || (r_state == S_FLD)) && !r_wb;
        w_div_start = (r_state == S_DIVST) && (r_den2 > 0);
        w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_step      <= '0;
            r_wb        <= 1'b0;
            r_fld       <= '0;
            r_mu        <= '0;
            r_kappa     <= '0;
            r_mass      <= '0;
            r_pair      <= '0;
            r_alpha     <= '0;
            r_inv       <= (DW-1)'(Q_ONE);
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MU:    r_mu    <= i_cfg_data;
                    CFG_KAPPA: r_kappa <= i_cfg_data[DW-2:0];
                    CFG_MASS:  r_mass  <= i_cfg_data[DW-2:0];
                    CFG_PAIR:  r_pair  <= i_cfg_data;
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_INV:   r_inv   <= i_cfg_data[DW-2:0];
                    default:   ;
                endcase
            end
            case (r_state)
                S_DEC2: r_k <= '0;
                S_READ: r_k <= r_k + 1'b1;
                S_DIVST, S_FIN: begin
                    r_step <= '0;
                    r_wb   <= 1'b0;
                end
                S_PRE, S_FLD: begin
                    r_wb <= !r_wb;
                    if (r_wb) r_step <= r_step + 1'b1;
                end
                default: begin
                    r_step <= '0;
                    r_wb   <= 1'b0;
                end
            endcase
            if (r_state == S_DEC2) begin
                r_fld <= '0;
            end else if (r_state == S_FIN) begin
                r_fld <= r_fld + 1'b1;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc_in) r_cell <= i_req.cell_index;
        if (r_state == S_DEC1) begin
            r_x <= w_xq[XW-1:0];
            r_t <= TW'(r_cell - CIW'(w_xq[XW-1:0]) * CIW'(NN));
        end
        if (r_state == S_DEC2) begin
            r_y <= w_ynext;
            r_z <= w_znext;
            for (int f = 0; f < 3; f++) r_res[f] <= '0;
        end
        if (r_state == S_READ && r_k != '0) begin
            r_nb[NBW'(r_k - 1'b1)] <= w_rdata;
        end
        if (r_state == S_DIVST) r_quo <= '0;
        if (r_state == S_DIV && w_div_done) r_quo <= w_div_quo;
        if (r_state == S_FIN) r_res[r_fld] <= w_fin;
        if (w_out_load) begin
            for (int f = 0; f < 3; f++) r_out[f] <= r_res[f];
        end
        if ((r_state == S_PRE || r_state == S_FLD) && r_wb) begin
            case (w_uop.dst)
                D_IDX2: r_idx2 <= w_sat;
                D_G:    r_g[4'(3 * w_uop.idx + w_fld)] <= w_sat;
                D_T1:   r_t1   <= w_sat;
                D_PP:   r_pp   <= w_sat;
                D_PP2:  r_pp2  <= w_sat;
                D_KPP:  r_kpp  <= w_sat;
                D_DEN2: r_den2 <= w_sat;
                D_NUM:  r_num  <= w_sat;
                D_LAP:  r_lap  <= w_sat;
                D_DV:   r_dv[w_uop.idx - 1'b1] <= w_sat;
                D_ACC0: r_acc  <= ACC_W'(w_full);
                D_ACC:  r_acc  <= r_acc + ACC_W'(w_full);
                D_ACC2: r_acc  <= r_acc + (ACC_W'(w_full) <<< 1);
                D_CORR: r_corr <= sat32(-(64'(w_full)));
                D_DP:   r_dp   <= w_sat;
                D_FTR:  r_ftr  <= w_sat;
                D_FPW:  r_fpw  <= w_sat;
                D_FM:   r_fm   <= w_sat;
                default: ;
            endcase
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.accel_a = r_out[0];
    assign o_res.accel_b = r_out[1];
    assign o_res.accel_c = r_out[2];

`ifndef SYNTHESIS
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait");
    a_write_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_req.req_type == REQ_WRITE && !r_out_valid) |=> !r_out_valid)
        else $error("write produced a result beat");
    a_fld_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLD) |-> (r_fld != 2'd3) && (r_step < SW'(FLD_N)))
        else $error("field sequencer out of range");
`endif
endmodule

// ===== rtl/mcfs_store.sv =====
// Field store: one word of three fields per cell, one write and one read port.
// Depends on mcfs_pkg.
module mcfs_store import mcfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [WW-1:0] o_rdata
);
    logic [WW-1:0] mem [CELLS];
    logic [WW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mcfs_mul.sv =====
// Shared Q12.20 multiplier: registered floor(a*b / 2^20), full and saturated.
// Depends on mcfs_pkg.
module mcfs_mul import mcfs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [OPA_W-1:0]  i_a,
    input  logic signed [OPB_W-1:0]  i_b,
    output logic signed [FULL_W-1:0] o_full,
    output logic signed [DW-1:0]     o_sat
);
    logic signed [PROD_W-1:0] w_prod;
    logic signed [FULL_W-1:0] r_full;

    assign w_prod = PROD_W'(i_a) * PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_full <= w_prod[PROD_W-1:FRAC];
        end
    end

    assign o_full = r_full;
    assign o_sat  = sat32(64'(r_full));
endmodule

// ===== rtl/mcfs_div.sv =====
// Restoring divider, one quotient bit per cycle: sat32(sign * (|n| << 20) / d).
// Depends on mcfs_pkg.
module mcfs_div import mcfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic [DD_W-1:0]      i_den,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quo
);
    logic [DCW-1:0]    r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [DIVN_W-1:0] r_q;
    logic [DW-1:0]     r_rem;
    logic [DD_W-1:0]   r_den;
    logic signed [DW-1:0] r_quo;

    logic [DW:0]       w_sh;
    logic [DW:0]       w_sub;
    logic              w_ge;
    logic [DW-1:0]     w_mag;
    logic [DIVN_W-1:0] w_qn;

    assign w_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign w_sh  = {r_rem, r_q[DIVN_W-1]};
    assign w_sub = w_sh - (DW+1)'(r_den);
    assign w_ge  = !w_sub[DW];
    assign w_qn  = {r_q[DIVN_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCW'(DIVN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {w_mag, FRAC'(0)};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[DW-1];
        end else if (r_busy) begin
            r_q   <= w_qn;
            r_rem <= w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
            if (r_cnt == DCW'(1)) begin
                r_quo <= r_neg ? sat32(-(64'(w_qn))) : sat32(64'(w_qn));
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider count out of range");
`endif
endmodule
